// ----- sv/detection_box_cluster_merge_defines.svh -----
// Assertion macros for the detection box cluster merge block.
`ifndef DETECTION_BOX_CLUSTER_MERGE_DEFINES_SVH
`define DETECTION_BOX_CLUSTER_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
`define DBCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DBCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DBCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/dbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbcm_pkg
// Shared constants and types of the detection box cluster merge block.
// ----------------------------------------------------------------------------
package dbcm_pkg;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_BITS_DEF   = 12;
  localparam int WEIGHT_BITS      = 10;
  localparam int PCT_BITS         = 7;
  localparam int IDX_BITS_OUT     = 4;
  localparam logic [PCT_BITS-1:0] PCT_RESET = 7'd80;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 10'd1023;

  localparam logic [1:0] OC_MERGED  = 2'd0;
  localparam logic [1:0] OC_NEW     = 2'd1;
  localparam logic [1:0] OC_DROPPED = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

// ----- sv/dbcm_if.sv -----
// ----------------------------------------------------------------------------
// dbcm_in_if / dbcm_out_if
// Valid/ready channels for boxes and results.
// ----------------------------------------------------------------------------
interface dbcm_in_if #(parameter int CB = 12);
  logic          valid;
  logic          ready;
  logic [CB-1:0] box_x;
  logic [CB-1:0] box_y;
  logic [CB-1:0] box_width;
  logic [CB-1:0] box_height;
  logic          first_box;
  logic          last_box;
  modport source (output valid, box_x, box_y, box_width, box_height, first_box,
                  last_box, input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, first_box,
                last_box, output ready);
endinterface

interface dbcm_out_if #(parameter int CB = 12);
  logic          valid;
  logic          ready;
  logic          kind;
  logic [3:0]    cluster_index;
  logic [1:0]    outcome;
  logic [CB-1:0] out_x;
  logic [CB-1:0] out_y;
  logic [CB-1:0] out_width;
  logic [CB-1:0] out_height;
  logic [9:0]    out_weight;
  logic          end_of_run;
  modport source (output valid, kind, cluster_index, outcome, out_x, out_y,
                  out_width, out_height, out_weight, end_of_run, input ready);
  modport sink (input valid, kind, cluster_index, outcome, out_x, out_y,
                out_width, out_height, out_weight, end_of_run, output ready);
endinterface

// ----- sv/dbcm_ram.sv -----
// ----------------------------------------------------------------------------
// dbcm_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module dbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/dbcm_div.sv -----
// ----------------------------------------------------------------------------
// dbcm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbcm_div
  import dbcm_pkg::*;
#(
  parameter int NB = 22,
  parameter int DB = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic [NB-1:0] quo,
  output div_ctl_t      ctl
);
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] q_r, q_nxt;
  logic [DB:0]   rem_r, rem_nxt;
  logic [DB-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DB:0]   trial;

  always_comb begin
    trial   = {rem_r[DB-1:0], q_r[NB-1]};
    q_nxt   = {q_r[NB-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NB);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo       = q_r;
  assign ctl.start = start;
  assign ctl.busy  = (cnt_r != '0);
endmodule

// ----- sv/detection_box_cluster_merge.sv -----
// ----------------------------------------------------------------------------
// detection_box_cluster_merge
// Groups detection boxes into weighted clusters held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage: boxes enter on in_ (valid/ready), one beat per box. Results leave
// on out_: one status beat per box, then on last_box one dump beat per
// cluster; end_of_run marks the final beat of each box. cfg_we writes the
// overlap percent (reset 80); the user writes it only while the block is
// idle, which the block itself does not enforce.
// Timing: one box at a time. Each cluster is tested in steps: issue, RAM
// read, latch, area products, percent products, decide. A merge runs four
// serial divisions, each a start and a collect, then a write-back. A first
// box or a box on an empty table gives its status beat the cycle after it
// is taken. A dump reads and sends each cluster, with receiver stalls.
// Reset clears the cluster count and the controller; the RAM is not
// cleared, since only entries below the count are read.
// A stalled receiver holds the output register; the block waits on it and
// takes no new box until its results are all delivered.
// ----------------------------------------------------------------------------
`include "detection_box_cluster_merge_defines.svh"
module detection_box_cluster_merge
  import dbcm_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  dbcm_in_if.sink             in_ch,
  dbcm_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [PCT_BITS-1:0] cfg_wdata
);
  localparam int CB  = COORD_BITS;
  localparam int AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNW = $clog2(MAX_CLUSTERS + 1);
  localparam int WB  = WEIGHT_BITS;
  localparam int EW  = 4 * CB + WB;
  localparam int NB  = CB + WB;
  localparam int DB  = WB + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_T1    = 4'd2;
  localparam logic [3:0] S_T2    = 4'd3;
  localparam logic [3:0] S_T3    = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_DRD   = 4'd9;
  localparam logic [3:0] S_DOUT  = 4'd10;
  localparam logic [3:0] S_TEST  = 4'd11;

  logic [3:0]          st_r;
  logic [PCT_BITS-1:0] pct_r;
  logic [CNW-1:0]      cnt_r;
  logic [CNW-1:0]      i_r;
  logic [CB-1:0]       bx_r, by_r, bw_r, bh_r;
  logic                last_r;
  logic [1:0]          dsel_r;
  logic [EW-1:0]       ent_r;

  // output register
  logic                ov_r, okind_r, oend_r;
  logic [3:0]          oidx_r;
  logic [1:0]          ooc_r;
  logic [CB-1:0]       ox_r, oy_r, ow_r, oh_r;
  logic [WB-1:0]       owt_r;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  dbcm_ram #(.WIDTH(EW), .DEPTH(MAX_CLUSTERS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // entry layout {left, top, wide, tall, weight}
  logic [CB-1:0] el, et, ew, eh;
  logic [WB-1:0] ewt;
  assign {el, et, ew, eh, ewt} = ent_r;

  // overlap test pipeline
  logic [CB:0]     ax, ay, cx, cy, r1, r2, b1, b2;
  logic [2*CB-1:0] a1_r, a2_r, small_area;
  logic [2*CB+1:0] inter_r;
  logic            isect_r;
  logic [2*CB+8:0] lhs_r, rhs_r;
  assign ax = ({1'b0, el} > {1'b0, bx_r}) ? {1'b0, el} : {1'b0, bx_r};
  assign ay = ({1'b0, et} > {1'b0, by_r}) ? {1'b0, et} : {1'b0, by_r};
  assign r1 = {1'b0, el} + {1'b0, ew};
  assign r2 = {1'b0, bx_r} + {1'b0, bw_r};
  assign b1 = {1'b0, et} + {1'b0, eh};
  assign b2 = {1'b0, by_r} + {1'b0, bh_r};
  assign cx = (r1 < r2) ? r1 : r2;
  assign cy = (b1 < b2) ? b1 : b2;
  assign small_area = (a1_r < a2_r) ? a1_r : a2_r;

  // divider: (old*w + new) / (w+1)
  logic          dstart;
  logic [NB-1:0] dnum, dquo;
  div_ctl_t      dctl;
  logic [CB-1:0] dold, dnew;
  logic [CB-1:0] nl_r, nt_r, nw_r, nh_r;

  always_comb begin
    case (dsel_r)
      2'd0:    begin dold = ew; dnew = bw_r; end
      2'd1:    begin dold = eh; dnew = bh_r; end
      2'd2:    begin dold = el; dnew = bx_r; end
      default: begin dold = et; dnew = by_r; end
    endcase
  end
  assign dnum = NB'(dold) * NB'(ewt) + NB'(dnew);

  dbcm_div #(.NB(NB), .DB(DB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum),
    .den(DB'(ewt) + DB'(1)), .quo(dquo), .ctl(dctl)
  );

  logic          accept, ofree, ov_set;
  logic [WB-1:0] wt_inc;
  assign ofree  = !ov_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign dstart = (st_r == S_DIV);
  assign wt_inc = (ewt < WEIGHT_MAX) ? ewt + WB'(1) : ewt;
  assign raddr  = i_r[AW-1:0];

  // a new beat enters the output register this cycle
  always_comb begin
    case (st_r)
      S_IDLE:  ov_set = accept && (in_ch.first_box || cnt_r == '0);
      S_TEST:  ov_set = (i_r >= cnt_r) && ofree;
      S_WR:    ov_set = ofree;
      S_DOUT:  ov_set = ofree;
      default: ov_set = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i_r[AW-1:0];
    wdata = {bx_r, by_r, bw_r, bh_r, WB'(1)};
    if (st_r == S_WR) begin
      we    = 1'b1;
      wdata = {nl_r, nt_r, nw_r, nh_r, wt_inc};
    end else if (accept) begin
      we    = in_ch.first_box || (cnt_r == '0);
      waddr = '0;
      wdata = {in_ch.box_x, in_ch.box_y, in_ch.box_width, in_ch.box_height, WB'(1)};
    end else if (st_r == S_TEST && i_r >= cnt_r && cnt_r < CNW'(MAX_CLUSTERS)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      pct_r <= PCT_RESET;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_we) pct_r <= cfg_wdata;
      if (ov_set) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (accept) begin
            bx_r <= in_ch.box_x; by_r <= in_ch.box_y;
            bw_r <= in_ch.box_width; bh_r <= in_ch.box_height;
            last_r <= in_ch.last_box;
            i_r <= '0;
            if (in_ch.first_box || cnt_r == '0) begin
              cnt_r <= CNW'(1);
              okind_r <= KIND_STATUS; oidx_r <= '0; ooc_r <= OC_NEW;
              ox_r <= in_ch.box_x; oy_r <= in_ch.box_y;
              ow_r <= in_ch.box_width; oh_r <= in_ch.box_height;
              owt_r <= WB'(1); oend_r <= !in_ch.last_box;
              st_r <= in_ch.last_box ? S_DRD : S_IDLE;
            end else begin
              st_r <= S_TEST;
            end
          end
        end
        S_TEST: begin
          // i_r indexes next cluster to test
          if (i_r < cnt_r) begin
            st_r <= S_RD;
          end else if (ofree) begin
            okind_r <= KIND_STATUS; oend_r <= !last_r;
            if (cnt_r < CNW'(MAX_CLUSTERS)) begin
              oidx_r <= 4'(i_r); ooc_r <= OC_NEW;
              ox_r <= bx_r; oy_r <= by_r; ow_r <= bw_r; oh_r <= bh_r; owt_r <= WB'(1);
              cnt_r <= cnt_r + CNW'(1);
            end else begin
              oidx_r <= '0; ooc_r <= OC_DROPPED;
              ox_r <= '0; oy_r <= '0; ow_r <= '0; oh_r <= '0; owt_r <= '0;
            end
            i_r <= '0;
            st_r <= last_r ? S_DRD : S_IDLE;
          end
        end
        S_RD: st_r <= S_T1;
        S_T1: begin
          ent_r <= rdata;
          st_r <= S_T2;
        end
        S_T2: begin
          isect_r <= (ax <= cx) && (ay <= cy);
          inter_r <= (2*CB+2)'((cx - ax) * (cy - ay));
          a1_r <= ew * eh;
          a2_r <= bw_r * bh_r;
          st_r <= S_T3;
        end
        S_T3: begin
          lhs_r <= (2*CB+9)'(inter_r) * (2*CB+9)'(100);
          rhs_r <= (2*CB+9)'(small_area) * (2*CB+9)'(pct_r);
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (isect_r && lhs_r >= rhs_r) begin
            dsel_r <= 2'd0;
            st_r <= S_DIV;
          end else begin
            i_r <= i_r + CNW'(1);
            st_r <= S_TEST;
          end
        end
        S_DIV: st_r <= S_DWAIT;
        S_DWAIT: begin
          if (!dctl.busy) begin
            case (dsel_r)
              2'd0:    nw_r <= dquo[CB-1:0];
              2'd1:    nh_r <= dquo[CB-1:0];
              2'd2:    nl_r <= dquo[CB-1:0];
              default: nt_r <= dquo[CB-1:0];
            endcase
            dsel_r <= dsel_r + 2'd1;
            st_r <= (dsel_r == 2'd3) ? S_WR : S_DIV;
          end
        end
        S_WR: begin
          if (ofree) begin
            okind_r <= KIND_STATUS; oidx_r <= 4'(i_r); ooc_r <= OC_MERGED;
            ox_r <= nl_r; oy_r <= nt_r; ow_r <= nw_r; oh_r <= nh_r;
            owt_r <= wt_inc; oend_r <= !last_r;
            i_r <= '0;
            st_r <= last_r ? S_DRD : S_IDLE;
          end
        end
        S_DRD: st_r <= S_DOUT;
        S_DOUT: begin
          if (ofree) begin
            okind_r <= KIND_DUMP; oidx_r <= 4'(i_r); ooc_r <= OC_MERGED;
            {ox_r, oy_r, ow_r, oh_r, owt_r} <= rdata;
            oend_r <= (i_r + CNW'(1) >= cnt_r);
            i_r <= i_r + CNW'(1);
            st_r <= (i_r + CNW'(1) >= cnt_r) ? S_IDLE : S_DRD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // merge write repeats while S_WR waits on the output register; same data
  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = okind_r;
  assign out_ch.cluster_index = oidx_r;
  assign out_ch.outcome       = ooc_r;
  assign out_ch.out_x         = ox_r;
  assign out_ch.out_y         = oy_r;
  assign out_ch.out_width     = ow_r;
  assign out_ch.out_height    = oh_r;
  assign out_ch.out_weight    = owt_r;
  assign out_ch.end_of_run    = oend_r;

  `DBCM_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNW'(MAX_CLUSTERS), "count overflow")
  `DBCM_ASSERT_IMPL(a_no_acc_busy, clk, rst_n, accept, st_r == S_IDLE && !ov_r, "accept while busy")
  `DBCM_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(oidx_r), "output dropped")
endmodule

// ----- tb/detection_box_cluster_merge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_cluster_merge_tb
// Feeds boxes through the cluster merge block. A directed table comes first,
// then random runs of boxes that tend to overlap their clusters. Each result
// beat is compared with the cluster table kept in the testbench. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module detection_box_cluster_merge_tb;
  import dbcm_pkg::*;

  localparam int NCL = 16;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic        first;
    logic        last;
  } box_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [1:0]  outcome;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [9:0]  weight;
    logic        eor;
  } beat_t;

  // Directed row: box, an optional typed-in status beat and a percent
  // written before the box goes in.
  typedef struct packed {
    box_t  b;
    logic  has_status;
    beat_t status;
    logic  do_cfg;
    logic [6:0] pct;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [PCT_BITS-1:0] cfg_wdata = '0;

  dbcm_in_if  #(.CB(12)) in_ch ();
  dbcm_out_if #(.CB(12)) out_ch ();

  detection_box_cluster_merge dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Cluster table as the block should hold it.
  logic [11:0] cl_x [NCL];
  logic [11:0] cl_y [NCL];
  logic [11:0] cl_w [NCL];
  logic [11:0] cl_h [NCL];
  logic [9:0]  cl_wt [NCL];
  int          cl_count = 0;
  logic [6:0]  pct = PCT_RESET;

  beat_t       beats_due[$];
  int          errors = 0;
  int          mismatches = 0;
  bit          sending = 1'b1;
  int          hold_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic bit box_hits(int i, box_t b);
    longint unsigned ax, ay, cx, cy, a1, a2, sm, inter;
    ax = (cl_x[i] > b.x) ? cl_x[i] : b.x;
    ay = (cl_y[i] > b.y) ? cl_y[i] : b.y;
    cx = ((cl_x[i] + 64'd0 + cl_w[i]) < (b.x + 64'd0 + b.w)) ?
         (cl_x[i] + 64'd0 + cl_w[i]) : (b.x + 64'd0 + b.w);
    cy = ((cl_y[i] + 64'd0 + cl_h[i]) < (b.y + 64'd0 + b.h)) ?
         (cl_y[i] + 64'd0 + cl_h[i]) : (b.y + 64'd0 + b.h);
    if (ax > cx || ay > cy) return 1'b0;
    a1 = cl_w[i] * 64'd1 * cl_h[i];
    a2 = b.w * 64'd1 * b.h;
    sm = (a1 < a2) ? a1 : a2;
    inter = (cx - ax) * (cy - ay);
    return 100 * inter >= pct * sm;
  endfunction

  function automatic logic [11:0] average(logic [11:0] old, logic [11:0] nw,
                                          logic [9:0] wt);
    longint unsigned s;
    s = old * 64'd1 * wt + nw;
    return 12'(s / (wt + 64'd1));
  endfunction

  function automatic beat_t mk(logic kind, int idx, logic [1:0] oc,
                               logic [11:0] x, logic [11:0] y, logic [11:0] w,
                               logic [11:0] h, logic [9:0] wt);
    beat_t r;
    r = '{kind, 4'(idx), oc, x, y, w, h, wt, 1'b0};
    return r;
  endfunction

  // Update the cluster table with one box and queue its result beats.
  task automatic merge_box(box_t b);
    beat_t st;
    bit    hit;
    hit = 1'b0;
    if (b.first) begin
      cl_x[0] = b.x; cl_y[0] = b.y; cl_w[0] = b.w; cl_h[0] = b.h; cl_wt[0] = 1;
      cl_count = 1;
      st = mk(KIND_STATUS, 0, OC_NEW, b.x, b.y, b.w, b.h, 1);
      hit = 1'b1;
    end
    for (int i = 0; !hit && i < cl_count; i++) begin
      if (box_hits(i, b)) begin
        cl_w[i] = average(cl_w[i], b.w, cl_wt[i]);
        cl_h[i] = average(cl_h[i], b.h, cl_wt[i]);
        cl_x[i] = average(cl_x[i], b.x, cl_wt[i]);
        cl_y[i] = average(cl_y[i], b.y, cl_wt[i]);
        if (cl_wt[i] < WEIGHT_MAX) cl_wt[i]++;
        st = mk(KIND_STATUS, i, OC_MERGED, cl_x[i], cl_y[i], cl_w[i], cl_h[i],
                cl_wt[i]);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (cl_count < NCL) begin
        cl_x[cl_count] = b.x; cl_y[cl_count] = b.y;
        cl_w[cl_count] = b.w; cl_h[cl_count] = b.h; cl_wt[cl_count] = 1;
        st = mk(KIND_STATUS, cl_count, OC_NEW, b.x, b.y, b.w, b.h, 1);
        cl_count++;
      end else begin
        st = mk(KIND_STATUS, 0, OC_DROPPED, 0, 0, 0, 0, 0);
      end
    end
    st.eor = !(b.last && cl_count > 0);
    beats_due = {beats_due, st};
    if (b.last) begin
      for (int i = 0; i < cl_count; i++) begin
        st = mk(KIND_DUMP, i, OC_MERGED, cl_x[i], cl_y[i], cl_w[i], cl_h[i],
                cl_wt[i]);
        st.eor = (i == cl_count - 1);
        beats_due = {beats_due, st};
      end
    end
  endtask

  // Result checker and receiver stall pattern.
  initial begin
    beat_t got, want;
    int    phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.cluster_index, out_ch.outcome, out_ch.out_x,
                out_ch.out_y, out_ch.out_width, out_ch.out_height,
                out_ch.out_weight, out_ch.end_of_run};
        if (beats_due.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected beat %h", got);
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if ((phase / 64) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_box(box_t b);
    in_ch.valid <= 1'b1;
    {in_ch.box_x, in_ch.box_y, in_ch.box_width, in_ch.box_height,
     in_ch.first_box, in_ch.last_box} <= b;
    do @(posedge clk); while (!in_ch.ready);
    merge_box(b);
  endtask

  // Random gap after a burst; drops valid only when a gap really follows.
  int burst_left = 0;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_pct(logic [6:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pct = v;
  endtask

  function automatic box_t near_box(int i);
    box_t b;
    b.x = cl_x[i] + 12'($urandom_range(0, 6)) - 12'd3;
    b.y = cl_y[i] + 12'($urandom_range(0, 6)) - 12'd3;
    b.w = cl_w[i] + 12'($urandom_range(0, 4)) - 12'd2;
    b.h = cl_h[i] + 12'($urandom_range(0, 4)) - 12'd2;
    b.first = 1'b0;
    b.last = ($urandom_range(0, 15) == 0);
    return b;
  endfunction

  row_t rows[$];

  function automatic row_t r(logic [11:0] x, logic [11:0] y, logic [11:0] w,
                             logic [11:0] h, logic f, logic l);
    row_t t;
    t = '0;
    t.b = '{x, y, w, h, f, l};
    return t;
  endfunction

  initial begin
    row_t  t;
    box_t  b;
    int    sel;
    in_ch.valid = 1'b0;
    {in_ch.box_x, in_ch.box_y, in_ch.box_width, in_ch.box_height,
     in_ch.first_box, in_ch.last_box} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Last box right after reset opens cluster 0; a one-entry dump follows.
    t = r(12'd100, 12'd100, 12'd50, 12'd50, 1'b0, 1'b1);
    t.has_status = 1'b1;
    t.status = '{KIND_STATUS, 4'd0, OC_NEW, 12'd100, 12'd100, 12'd50, 12'd50,
                 10'd1, 1'b0};
    rows = {rows, t};
    rows = {rows, r(12'd102, 12'd101, 12'd50, 12'd49, 1'b0, 1'b0)};
    t = r(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0);
    t.has_status = 1'b1;
    t.status = '{KIND_STATUS, 4'd0, OC_NEW, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                 10'd1, 1'b1};
    rows = {rows, t};
    rows = {rows, r(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b0)};
    rows = {rows, r(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0)};
    rows = {rows, r(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0)};
    // touching edges, zero area intersection
    rows = {rows, r(12'd10, 12'd10, 12'd10, 12'd10, 1'b1, 1'b0)};
    rows = {rows, r(12'd20, 12'd10, 12'd10, 12'd10, 1'b0, 1'b0)};
    t = r(12'd20, 12'd20, 12'd10, 12'd10, 1'b0, 1'b0);
    t.do_cfg = 1'b1; t.pct = 7'd0;
    rows = {rows, t};
    t = r(12'd15, 12'd15, 12'd10, 12'd10, 1'b0, 1'b1);
    t.do_cfg = 1'b1; t.pct = 7'd127;
    rows = {rows, t};
    t = r(12'd15, 12'd15, 12'd10, 12'd0, 1'b0, 1'b0);
    t.do_cfg = 1'b1; t.pct = 7'd100;
    rows = {rows, t};
    rows = {rows, r(12'd10, 12'd10, 12'd10, 12'd10, 1'b0, 1'b0)};
    t = r(12'd500, 12'd600, 12'd40, 12'd30, 1'b1, 1'b1);
    t.do_cfg = 1'b1; t.pct = 7'd1;
    rows = {rows, t};
    // fill the table with far apart boxes; the last filler and one more are dropped
    for (int i = 1; i < 17; i++)
      rows = {rows, r(12'(i * 200), 12'd5, 12'd20, 12'd20, 1'b0, i == 16)};
    rows = {rows, r(12'd700, 12'd5, 12'd20, 12'd20, 1'b0, 1'b0)};

    foreach (rows[k]) begin
      if (rows[k].do_cfg) write_pct(rows[k].pct);
      if (rows[k].has_status) begin
        // expected status typed into the table; check it against the table too
        send_box(rows[k].b);
        if (beats_due.size() == 0 || beats_due[beats_due.size() -
            (rows[k].b.last ? cl_count + 1 : 1)] !== rows[k].status) begin
          errors++;
          if (mismatches++ < 10) $display("table row %0d disagrees", k);
        end
      end else begin
        send_box(rows[k].b);
      end
      pace();
    end

    write_pct(7'd80);
    for (int n = 0; n < 130; n++) begin
      if (n == 40) write_pct(7'd50);
      if (n == 80) begin
        // long receiver hold-off while the bench keeps offering boxes
        hold_cycles = 400;
      end
      if (n == 100) wait_idle();
      if (n == 120) write_pct(7'd100);
      sel = $urandom_range(0, 9);
      if (cl_count == 0 || sel == 0) begin
        b = 50'({$urandom(), $urandom()});
        b.first = ($urandom_range(0, 3) == 0);
        b.last = ($urandom_range(0, 7) == 0);
      end else if (sel < 8) begin
        b = near_box($urandom_range(0, cl_count - 1));
      end else begin
        b.x = 12'($urandom_range(0, 3800)); b.y = 12'($urandom_range(0, 3800));
        b.w = 12'($urandom_range(1, 200)); b.h = 12'($urandom_range(1, 200));
        b.first = ($urandom_range(0, 5) == 0);
        b.last = ($urandom_range(0, 5) == 0);
      end
      send_box(b);
      pace();
    end
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
